// ===== sv/rcpd_pkg.sv =====
// Shared types and constants of the RC paddle digitiser.
package rcpd_pkg;

   // Width of the charge-time tick counter
   localparam int COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   // Compare width that holds both the counter and the 16-bit timeout
   localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
   localparam int STEP_W = $clog2(COUNT_WIDTH);

   localparam logic [7:0] POS_MAX = 8'd255;
   localparam logic [6:0] DISCONNECTED_MUL = 7'd127;

   // Configuration register indices
   localparam logic [1:0] CSR_DISCHARGE_TICKS = 2'd0;
   localparam logic [1:0] CSR_DIVIDER         = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   // Scan phases
   localparam logic [1:0] PH_DISCHARGE_0 = 2'd0;
   localparam logic [1:0] PH_COUNT_0     = 2'd1;
   localparam logic [1:0] PH_DISCHARGE_1 = 2'd2;
   localparam logic [1:0] PH_COUNT_1     = 2'd3;

   typedef struct packed {
      logic pot_level_0;
      logic pot_level_1;
      logic button_0_level;
      logic button_1_level;
   } req_type;

   typedef struct packed {
      logic       discharge_0;
      logic       discharge_1;
      logic       report_valid;
      logic [7:0] paddle_x;
      logic [7:0] paddle_y;
      logic [1:0] pressed_buttons;
      logic       changed;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic load_plain;
      logic div_start;
      logic div_step;
      logic div_next;
      logic load_report;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic report_now;
      logic div_last;
      logic div_sel;
      logic rsp_valid;
   } status_type;

endpackage

// ===== sv/rcpd_ctrl.sv =====
// Controller state machine of the RC paddle digitiser.
module rcpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                rsp_stall,
   input  rcpd_pkg::status_type status,
   output rcpd_pkg::cmd_type    cmd
);
   import rcpd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           out_free;
   logic           accept;

   // Output register is free when empty or being taken this cycle
   assign out_free  = !status.rsp_valid || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (status.report_now) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.load_plain = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               if (!status.div_sel) begin
                  cmd.div_next = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_report = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/rcpd_dp.sv =====
// Datapath of the RC paddle digitiser: scan counters, shared divider, result register.
module rcpd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   input  rcpd_pkg::req_type    req_payload,
   input  logic                 rsp_stall,
   output rcpd_pkg::rsp_type    rsp_payload,
   output logic                 rsp_valid,
   input  rcpd_pkg::cmd_type    cmd,
   output rcpd_pkg::status_type status
);
   import rcpd_pkg::*;

   // Configuration
   logic [7:0]  discharge_ticks_ff;
   logic [7:0]  divider_ff;
   logic [15:0] timeout_ticks_ff;

   // Scan state
   logic [1:0]             scan_phase_ff, scan_phase_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [COUNT_WIDTH-1:0] paddle_count_ff [2];
   logic [COUNT_WIDTH-1:0] reported_count_ff [2];
   logic [1:0]             sampled_buttons_ff, sampled_buttons_in;
   logic [1:0]             reported_buttons_ff;
   logic                   pend_changed_ff;

   // Divider
   logic [COUNT_WIDTH-1:0] quo_ff, quo_in;
   logic [7:0]             rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff;
   logic                   sel_ff;
   logic [7:0]             pos_x_ff, pos_y_ff, pos_new;

   // Result register
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // Step combinational terms
   logic [7:0]             len;
   logic [7:0]             div_eff;
   logic [15:0]            lim;
   logic [CMP_W-1:0]       next;
   logic [14:0]            disc_raw;
   logic [COUNT_WIDTH-1:0] disc_count;
   logic                   idx;
   logic                   done;
   logic [COUNT_WIDTH-1:0] count_new;
   logic                   report_now;
   logic [8:0]             trial;
   logic                   qbit;

   assign len     = (discharge_ticks_ff == 8'd0) ? 8'd1 : discharge_ticks_ff;
   assign div_eff = (divider_ff == 8'd0) ? 8'd1 : divider_ff;
   assign lim     = (timeout_ticks_ff == 16'd0) ? 16'd1 : timeout_ticks_ff;
   assign next    = CMP_W'(tick_count_ff) + CMP_W'(1);
   assign idx     = scan_phase_ff[1];

   // Disconnected count: 127 * divider as written, saturated to the counter range
   assign disc_raw   = {divider_ff, 7'd0} - {7'd0, divider_ff};
   assign disc_count = (CMP_W'(disc_raw) > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                              : COUNT_WIDTH'(disc_raw);

   // Scan step for one tick
   always_comb begin
      scan_phase_in      = scan_phase_ff;
      tick_count_in      = tick_count_ff;
      sampled_buttons_in = sampled_buttons_ff;
      done               = 1'b0;
      count_new          = disc_count;
      if (!scan_phase_ff[0]) begin
         if ((scan_phase_ff == PH_DISCHARGE_0) && (tick_count_ff == '0)) begin
            sampled_buttons_in = {req_payload.button_1_level, req_payload.button_0_level};
         end
         if (next >= CMP_W'(len)) begin
            scan_phase_in = scan_phase_ff + 2'd1;
            tick_count_in = '0;
         end else begin
            tick_count_in = COUNT_WIDTH'(next);
         end
      end else begin
         if (idx ? req_payload.pot_level_1 : req_payload.pot_level_0) begin
            count_new = tick_count_ff;
            done      = 1'b1;
         end else if ((next >= CMP_W'(lim)) || (next >= CMP_W'(COUNT_MAX))) begin
            count_new = disc_count;
            done      = 1'b1;
         end else begin
            tick_count_in = COUNT_WIDTH'(next);
         end
         if (done) begin
            tick_count_in = '0;
            scan_phase_in = idx ? PH_DISCHARGE_0 : PH_DISCHARGE_1;
         end
      end
   end

   assign report_now = (scan_phase_ff == PH_COUNT_1) && done;

   // One restoring division step
   assign trial = {rem_ff, quo_ff[COUNT_WIDTH-1]};
   assign qbit  = (trial >= {1'b0, div_eff});
   assign rem_in = qbit ? 8'(trial - {1'b0, div_eff}) : trial[7:0];
   assign quo_in = {quo_ff[COUNT_WIDTH-2:0], qbit};
   // Clip to the position range and invert
   assign pos_new = (quo_in > COUNT_WIDTH'(POS_MAX)) ? 8'd0 : ~quo_in[7:0];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         discharge_ticks_ff <= 8'd10;
         divider_ff         <= 8'd25;
         timeout_ticks_ff   <= 16'hFFFF;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DISCHARGE_TICKS: discharge_ticks_ff <= csr_write_data[7:0];
            CSR_DIVIDER:         divider_ff         <= csr_write_data[7:0];
            CSR_TIMEOUT_TICKS:   timeout_ticks_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Advance the scan on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_phase_ff        <= PH_DISCHARGE_0;
         tick_count_ff        <= '0;
         paddle_count_ff[0]   <= '0;
         paddle_count_ff[1]   <= '0;
         reported_count_ff[0] <= '0;
         reported_count_ff[1] <= '0;
         sampled_buttons_ff   <= 2'b00;
         reported_buttons_ff  <= 2'b00;
      end else if (cmd.accept) begin
         scan_phase_ff      <= scan_phase_in;
         tick_count_ff      <= tick_count_in;
         sampled_buttons_ff <= sampled_buttons_in;
         if (done) begin
            paddle_count_ff[idx] <= count_new;
         end
         if (report_now) begin
            reported_count_ff[0] <= paddle_count_ff[0];
            reported_count_ff[1] <= count_new;
            reported_buttons_ff  <= sampled_buttons_ff;
         end
      end
   end

   // Capture the change flag against the previous report
   always_ff @(posedge clock) begin
      if (cmd.accept && report_now) begin
         pend_changed_ff <= (sampled_buttons_ff != reported_buttons_ff) ||
                            (paddle_count_ff[0] != reported_count_ff[0]) ||
                            (count_new != reported_count_ff[1]);
      end
   end

   // Shared divider: first paddle, then second paddle
   always_ff @(posedge clock) begin
      if (cmd.div_start || cmd.div_next) begin
         quo_ff  <= cmd.div_next ? paddle_count_ff[1] : paddle_count_ff[0];
         rem_ff  <= 8'd0;
         step_ff <= '0;
         sel_ff  <= cmd.div_next;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.div_step && status.div_last) begin
         if (sel_ff) begin
            pos_y_ff <= pos_new;
         end else begin
            pos_x_ff <= pos_new;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_plain) begin
         rsp_ff <= '{discharge_0:     !scan_phase_ff[0] && !idx,
                     discharge_1:     !scan_phase_ff[0] && idx,
                     report_valid:    1'b0,
                     paddle_x:        8'd0,
                     paddle_y:        8'd0,
                     pressed_buttons: 2'b00,
                     changed:         1'b0};
      end else if (cmd.load_report) begin
         rsp_ff <= '{discharge_0:     1'b0,
                     discharge_1:     1'b0,
                     report_valid:    1'b1,
                     paddle_x:        pos_x_ff,
                     paddle_y:        pos_y_ff,
                     pressed_buttons: ~reported_buttons_ff,
                     changed:         pend_changed_ff};
      end
   end

   // Hold the beat until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_plain || cmd.load_report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_payload       = rsp_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign status.report_now = report_now;
   assign status.div_last   = (step_ff == STEP_W'(COUNT_WIDTH - 1));
   assign status.div_sel    = sel_ff;
   assign status.rsp_valid  = rsp_valid_ff;

endmodule

// ===== sv/rc_paddle_digitizer.sv =====
// Top level of the RC paddle digitiser.
// Each accepted req beat is one timer tick and yields exactly one rsp beat. A scan discharges
// and times the first paddle pot, then the second; the tick that ends the second count carries
// the report (positions, pressed buttons, change flag). A new tick is taken each cycle while
// the rsp side keeps up and no report is being divided; the report tick is held by the single
// shared restoring divider, which spends one cycle per quotient bit on each paddle in turn.
// Configuration is written through csr_write_enable/csr_index/csr_write_data while no tick is
// in flight; a write to index 3 is ignored.
module rc_paddle_digitizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcpd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcpd_pkg::rsp_type rsp_payload
);
   import rcpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   rcpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcpd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .rsp_valid        (rsp_valid),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== dv/rcpd_scan_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RC paddle digitiser: watches all ports, predicts each tick and checks rsp beats.
module rcpd_scan_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rcpd_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rcpd_pkg::rsp_type rsp_payload,
   output int                mismatches,
   output int                pending_results,
   output int                reports_seen
);
   import rcpd_pkg::*;

   // Register copies
   logic [7:0]  discharge_len;
   logic [7:0]  divisor;
   logic [15:0] timeout_len;

   // Scan state
   logic [1:0]             scan_phase;
   logic [COUNT_WIDTH-1:0] tick_count;
   logic [COUNT_WIDTH-1:0] paddle_count [2];
   logic [COUNT_WIDTH-1:0] reported_count [2];
   logic [1:0]             sampled_btn;
   logic [1:0]             reported_btn;

   rsp_type expected_ticks [$];
   int      report_tally;

   initial begin
      mismatches = 0;
      pending_results = 0;
      reports_seen = 0;
      report_tally = 0;
   end

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   function automatic logic [7:0] paddle_position(input logic [COUNT_WIDTH-1:0] count);
      int unsigned step;
      int unsigned quot;
      step = (divisor == 8'd0) ? 1 : divisor;
      quot = count / step;
      if (quot > POS_MAX) quot = POS_MAX;
      return POS_MAX - quot[7:0];
   endfunction

   // Advance the scan by one tick and form the beat it should produce
   function automatic rsp_type advance_scan(input req_type tick);
      rsp_type     res;
      logic        which;
      logic        pin;
      logic        done;
      int unsigned lim;
      int unsigned nxt;
      int unsigned lost;
      res = '0;
      done = 1'b0;
      which = scan_phase[1];
      pin = which ? tick.pot_level_1 : tick.pot_level_0;
      if (scan_phase == PH_DISCHARGE_0 || scan_phase == PH_DISCHARGE_1) begin
         // Hold the pin low; buttons are taken on the very first tick of a scan
         lim = (discharge_len == 8'd0) ? 1 : discharge_len;
         if (scan_phase == PH_DISCHARGE_0 && tick_count == '0) begin
            sampled_btn = {tick.button_1_level, tick.button_0_level};
         end
         if (which) res.discharge_1 = 1'b1;
         else res.discharge_0 = 1'b1;
         nxt = tick_count + 1;
         if (nxt >= lim) begin
            scan_phase = scan_phase + 2'd1;
            tick_count = '0;
         end else begin
            tick_count = nxt[COUNT_WIDTH-1:0];
         end
      end else begin
         // Count until the pin reads high or the paddle looks disconnected
         lim = (timeout_len == 16'd0) ? 1 : timeout_len;
         if (pin) begin
            paddle_count[which] = tick_count;
            done = 1'b1;
         end else begin
            nxt = tick_count + 1;
            if (nxt >= lim || nxt >= COUNT_MAX) begin
               lost = int'(DISCONNECTED_MUL) * int'(divisor);
               if (lost > COUNT_MAX) lost = COUNT_MAX;
               paddle_count[which] = lost[COUNT_WIDTH-1:0];
               done = 1'b1;
            end else begin
               tick_count = nxt[COUNT_WIDTH-1:0];
            end
         end
         if (done) begin
            tick_count = '0;
            if (!which) begin
               scan_phase = PH_DISCHARGE_1;
            end else begin
               // End of scan: build the report and record it
               scan_phase = PH_DISCHARGE_0;
               res.report_valid = 1'b1;
               res.paddle_x = paddle_position(paddle_count[0]);
               res.paddle_y = paddle_position(paddle_count[1]);
               res.pressed_buttons = ~sampled_btn;
               res.changed = (sampled_btn != reported_btn) ||
                             (paddle_count[0] != reported_count[0]) ||
                             (paddle_count[1] != reported_count[1]);
               reported_btn = sampled_btn;
               reported_count[0] = paddle_count[0];
               reported_count[1] = paddle_count[1];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         discharge_len = 8'd10;
         divisor = 8'd25;
         timeout_len = 16'd65535;
         scan_phase = PH_DISCHARGE_0;
         tick_count = '0;
         paddle_count[0] = '0;
         paddle_count[1] = '0;
         reported_count[0] = '0;
         reported_count[1] = '0;
         sampled_btn = 2'b00;
         reported_btn = 2'b00;
         expected_ticks.delete();
      end else begin
         // Apply register writes; an unknown index is dropped
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DISCHARGE_TICKS: discharge_len = csr_write_data[7:0];
               CSR_DIVIDER:         divisor = csr_write_data[7:0];
               CSR_TIMEOUT_TICKS:   timeout_len = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_ticks.push_back(advance_scan(req_payload));
         end
         // Compare each accepted rsp beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               flag_mismatch("rsp beat with no tick outstanding", 0, 32'(rsp_payload));
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_payload.discharge_0 !== want.discharge_0)
                  flag_mismatch("discharge_0", want.discharge_0, rsp_payload.discharge_0);
               if (rsp_payload.discharge_1 !== want.discharge_1)
                  flag_mismatch("discharge_1", want.discharge_1, rsp_payload.discharge_1);
               if (rsp_payload.report_valid !== want.report_valid)
                  flag_mismatch("report_valid", want.report_valid, rsp_payload.report_valid);
               if (rsp_payload.paddle_x !== want.paddle_x)
                  flag_mismatch("paddle_x", want.paddle_x, rsp_payload.paddle_x);
               if (rsp_payload.paddle_y !== want.paddle_y)
                  flag_mismatch("paddle_y", want.paddle_y, rsp_payload.paddle_y);
               if (rsp_payload.pressed_buttons !== want.pressed_buttons)
                  flag_mismatch("pressed_buttons", want.pressed_buttons,
                                rsp_payload.pressed_buttons);
               if (rsp_payload.changed !== want.changed)
                  flag_mismatch("changed", want.changed, rsp_payload.changed);
               if (want.report_valid) report_tally++;
            end
         end
      end
      pending_results <= expected_ticks.size();
      reports_seen <= report_tally;
   end

endmodule

// ===== dv/rc_paddle_digitizer_test.sv =====
`timescale 1ns / 1ps
// Top of the RC paddle digitiser testbench: clock, reset, tick stimulus and verdict.
module rc_paddle_digitizer_test;
   import rcpd_pkg::*;

   // Index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // Pin odds: never charges, always high at once, otherwise high one tick in n
   localparam int PIN_NEVER = 0;
   localparam int PIN_AT_ONCE = 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_DISCHARGE_TICKS;
   logic [15:0] csr_write_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;

   int          mismatches;
   int          pending_results;
   int          reports_seen;

   // Receiver controls, changed only at clock edges
   logic        steady_rx = 1'b0;
   int          hold_bursts = 0;

   logic [1:0]  held_buttons = 2'b11;
   bit          steady_tx = 1'b0;
   int          ticks_sent = 0;

   always #5 clock = ~clock;

   rc_paddle_digitizer dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   rcpd_scan_checker scoreboard (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .mismatches(mismatches),
      .pending_results(pending_results),
      .reports_seen(reports_seen)
   );

   // Hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("rc_paddle_digitizer test failed");
      $finish;
   end

   // Receiver: random stalls, a calm stretch, and a long hold-off on request
   initial begin
      int seen_bursts;
      int hold_left;
      seen_bursts = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_bursts != seen_bursts) begin
            seen_bursts = hold_bursts;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (steady_rx) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 17);
         end
      end
   end

   // Write all three registers, one per edge, then drop the enable
   task automatic load_settings(input logic [15:0] disch, input logic [15:0] div,
                                input logic [15:0] tmo);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DISCHARGE_TICKS;
      csr_write_data <= disch;
      @(posedge clock);
      csr_index <= CSR_DIVIDER;
      csr_write_data <= div;
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_write_data <= tmo;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one tick, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_tick(input req_type tick);
      while (!steady_tx && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= tick;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   // Let the last beat land in the scoreboard, then wait for every result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   function automatic logic pin_level(input int odds);
      if (odds == PIN_NEVER) return 1'b0;
      return ($urandom_range(odds - 1) == 0);
   endfunction

   function automatic req_type random_tick(input int odds);
      req_type tick;
      if ($urandom_range(19) == 0) held_buttons = 2'($urandom_range(3));
      tick.pot_level_0 = pin_level(odds);
      tick.pot_level_1 = pin_level(odds);
      tick.button_0_level = held_buttons[0];
      tick.button_1_level = held_buttons[1];
      return tick;
   endfunction

   initial begin
      // Beats as {pot_level_0, pot_level_1, button_0_level, button_1_level}
      logic [3:0]  opening_zero [8];
      logic [3:0]  opening_short [6];
      logic [15:0] disch;
      logic [15:0] div;
      logic [15:0] tmo;
      int          odds;
      int          span;
      int          phase_no;

      // Two scans with zero registers: pins high at once, then disconnected
      opening_zero = '{4'b1100, 4'b1000, 4'b0111, 4'b1111,
                       4'b0010, 4'b0100, 4'b1001, 4'b1000};
      // A one-tick count on the first paddle, then the second paddle counts but neither charges nor times out
      opening_short = '{4'b0011, 4'b0011, 4'b1011, 4'b0011, 4'b0011, 4'b0011};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unused index must be dropped
      csr_write_enable <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_write_data <= 16'hFFFF;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);

      // Upper bits of the 8-bit registers are dropped, leaving zero
      load_settings(16'hFF00, 16'hFF00, 16'd0);
      foreach (opening_zero[i]) send_tick(opening_zero[i]);
      drain_results();
      load_settings(16'd1, 16'd1, 16'd3);
      foreach (opening_short[i]) send_tick(opening_short[i]);
      drain_results();

      phase_no = 0;
      while (ticks_sent < 1300 || reports_seen < 60) begin
         // Pick settings for this stretch; four-tick scans first for plenty of reports
         case (phase_no)
            0: begin
               disch = 16'd1; div = 16'd1; tmo = 16'd1; odds = 2; span = 240;
            end
            1: begin
               disch = 16'd255; div = 16'd255; tmo = 16'd65535; odds = 2; span = 300;
            end
            3: begin
               disch = 16'd1; div = 16'd1; tmo = 16'd400; odds = 300; span = 300;
            end
            default: begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: disch = 16'($urandom_range(1, 4));
                  6, 7:             disch = 16'($urandom_range(5, 20));
                  8:                disch = 16'd0;
                  default:          disch = 16'd255;
               endcase
               case ($urandom_range(5))
                  0:       div = 16'd1;
                  1:       div = 16'd12;
                  2:       div = 16'd25;
                  3:       div = 16'd255;
                  4:       div = 16'($urandom_range(1, 255));
                  default: div = 16'd0;
               endcase
               case ($urandom_range(3))
                  0:       tmo = 16'($urandom_range(1, 20));
                  1:       tmo = 16'($urandom_range(21, 1000));
                  2:       tmo = 16'd65535;
                  default: tmo = 16'd0;
               endcase
               case ($urandom_range(5))
                  0:       odds = PIN_AT_ONCE;
                  1:       odds = 2;
                  2:       odds = 8;
                  3:       odds = 40;
                  4:       odds = 400;
                  default: odds = (tmo <= 16'd1000) ? PIN_NEVER : 2;
               endcase
               span = $urandom_range(40, 200);
               if (disch > 16'd20) span += 600;
            end
         endcase
         load_settings(disch, div, tmo);

         // One calm stretch on both sides; one long receiver hold-off
         steady_tx = (phase_no == 2);
         steady_rx <= (phase_no == 2);
         if (phase_no == 1) hold_bursts <= hold_bursts + 1;

         repeat (span) send_tick(random_tick(odds));
         drain_results();
         phase_no++;
      end

      // Let any late beat show up before the verdict
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("rc_paddle_digitizer test passed");
      end else begin
         $display("rc_paddle_digitizer test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/rcpd_pkg.sv
sv/rcpd_ctrl.sv
sv/rcpd_dp.sv
sv/rc_paddle_digitizer.sv
dv/rcpd_scan_checker.sv
dv/rc_paddle_digitizer_test.sv
